>>> hdl/skt_pkg.sv
// Package for the sorted key table: sizes, field widths, codes and shared types.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package skt_pkg;

   localparam int CAPACITY      = 16;
   localparam int DATA_BITS     = 64;
   localparam int KEY_W         = 32;
   localparam int REC_W         = 64;
   localparam int STATUS_W      = 2;
   localparam int COUNT_FIELD_W = 5;
   localparam int IDX_W         = $clog2(CAPACITY);
   localparam int CNT_W         = $clog2(CAPACITY + 1);

   typedef enum logic {
      KIND_INSERT = 1'b0,
      KIND_FIND   = 1'b1
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_INSERTED  = 2'd0,
      STATUS_FOUND     = 2'd1,
      STATUS_NOT_FOUND = 2'd2,
      STATUS_FULL      = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INSERT,
      S_PLACE,
      S_FIND,
      S_DONE
   } state_type;

   typedef struct packed {
      logic signed [KEY_W-1:0] key;
      logic [DATA_BITS-1:0]    data;
   } entry_type;

   typedef struct packed {
      kind_type                kind;
      logic signed [KEY_W-1:0] key;
      logic [DATA_BITS-1:0]    data;
   } cmd_type;

   typedef struct packed {
      status_type               status;
      logic [REC_W-1:0]         found_data;
      logic [COUNT_FIELD_W-1:0] entry_count;
   } result_type;

endpackage

`default_nettype wire

>>> hdl/skt_if.sv
// Request and response channel interfaces of the sorted key table.
// Depends on skt_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface skt_req_if
   import skt_pkg::*;
   ();
   logic                    valid;
   logic                    ready;
   logic                    kind;
   logic signed [KEY_W-1:0] key;
   logic [REC_W-1:0]        record_data;

   modport source (output valid, output kind, output key, output record_data, input ready);
   modport sink   (input valid, input kind, input key, input record_data, output ready);
endinterface

interface skt_rsp_if
   import skt_pkg::*;
   ();
   logic                     valid;
   logic                     ready;
   logic [STATUS_W-1:0]      status;
   logic [REC_W-1:0]         found_data;
   logic [COUNT_FIELD_W-1:0] entry_count;

   modport source (output valid, output status, output found_data, output entry_count,
                   input ready);
   modport sink   (input valid, input status, input found_data, input entry_count,
                   output ready);
endinterface

`default_nettype wire

>>> hdl/skt_engine.sv
// Table engine: entry memory, fill count and the sequencer that scans and shifts entries.
// Depends on skt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module skt_engine
   import skt_pkg::*;
   (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start_valid,
   output logic            start_ready,
   input  wire cmd_type    cmd,
   output logic            result_valid,
   input  wire logic       result_ready,
   output result_type      result
   );

   entry_type mem [CAPACITY];
   entry_type rd_q_ff;

   state_type state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic signed [KEY_W-1:0] key_ff, key_in;
   logic [DATA_BITS-1:0] data_ff, data_in;
   logic [DATA_BITS-1:0] found_ff, found_in;
   status_type status_ff, status_in;

   logic rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type wr_entry;

   logic is_full, is_empty, key_lt, key_eq, at_first, at_last;
   logic [IDX_W-1:0] last_idx;

   assign is_full  = (count_ff == CNT_W'(CAPACITY));
   assign is_empty = (count_ff == '0);
   assign last_idx = IDX_W'(count_ff - CNT_W'(1));
   assign key_lt   = (key_ff < rd_q_ff.key);
   assign key_eq   = (key_ff == rd_q_ff.key);
   assign at_first = (idx_ff == '0);
   assign at_last  = ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start_valid) begin
               if (cmd.kind == KIND_INSERT) begin
                  state_in = (is_full || is_empty) ? S_DONE : S_INSERT;
               end else begin
                  state_in = is_empty ? S_DONE : S_FIND;
               end
            end
         end
         S_INSERT: begin
            if (!key_lt) begin
               state_in = S_DONE;
            end else if (at_first) begin
               state_in = S_PLACE;
            end
         end
         S_PLACE: state_in = S_DONE;
         S_FIND: begin
            if (key_eq || at_last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (result_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      start_ready  = 1'b0;
      result_valid = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = idx_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_entry     = '{key: key_ff, data: data_ff};
      idx_in       = idx_ff;
      count_in     = count_ff;
      key_in       = key_ff;
      data_in      = data_ff;
      found_in     = found_ff;
      status_in    = status_ff;
      case (state_ff)
         S_IDLE: begin
            start_ready = 1'b1;
            if (start_valid) begin
               key_in   = cmd.key;
               data_in  = cmd.data;
               found_in = '0;
               if (cmd.kind == KIND_INSERT) begin
                  status_in = STATUS_INSERTED;
                  if (is_full) begin
                     status_in = STATUS_FULL;
                  end else if (is_empty) begin
                     wr_en    = 1'b1;
                     wr_entry = '{key: cmd.key, data: cmd.data};
                     count_in = count_ff + CNT_W'(1);
                  end else begin
                     rd_en   = 1'b1;
                     rd_addr = last_idx;
                     idx_in  = last_idx;
                  end
               end else begin
                  status_in = STATUS_NOT_FOUND;
                  if (!is_empty) begin
                     rd_en   = 1'b1;
                     rd_addr = '0;
                     idx_in  = '0;
                  end
               end
            end
         end
         S_INSERT: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff + IDX_W'(1);
            if (key_lt) begin
               wr_entry = rd_q_ff;
               if (!at_first) begin
                  rd_en   = 1'b1;
                  rd_addr = idx_ff - IDX_W'(1);
                  idx_in  = idx_ff - IDX_W'(1);
               end
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         S_PLACE: begin
            wr_en    = 1'b1;
            count_in = count_ff + CNT_W'(1);
         end
         S_FIND: begin
            if (key_eq) begin
               status_in = STATUS_FOUND;
               found_in  = rd_q_ff.data;
            end else if (!at_last) begin
               rd_en   = 1'b1;
               rd_addr = idx_ff + IDX_W'(1);
               idx_in  = idx_ff + IDX_W'(1);
            end
         end
         S_DONE: result_valid = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_entry;
      end
      if (rd_en) begin
         rd_q_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      key_ff    <= key_in;
      data_ff   <= data_in;
      found_ff  <= found_in;
      status_ff <= status_in;
   end

   assign result.status      = status_ff;
   assign result.found_data  = REC_W'(found_ff);
   assign result.entry_count = COUNT_FIELD_W'(count_ff);

endmodule

`default_nettype wire

>>> hdl/sorted_key_table.sv
// Top level of the sorted key table: request intake, table engine and response register.
// Depends on skt_pkg, skt_if and skt_engine.
//
// The block keeps up to CAPACITY records in ascending signed key order. A request on
// req_bus either inserts its key and record_data after every entry with a key less than
// or equal to it, or finds the first entry with an equal key. Each request yields exactly
// one response on rsp_bus with a status, the found payload (zero unless found) and the
// number of stored entries afterward. An insert into a full table stores nothing and
// reports the full status.
// One request is worked on at a time. An insert reads the entries one per cycle from the
// end of the table toward its position, moving each one up a place as it goes; a find
// reads from the front one entry per cycle until the first match.
// The response sits in an output register, so the next request is accepted and worked
// on while a stalled response waits; the engine holds its own finished result until
// that register is free again.
// Synchronous reset empties the table and drops any pending response.
`timescale 1ns / 1ps
`default_nettype none

module sorted_key_table
   import skt_pkg::*;
   (
   input wire logic clock,
   input wire logic reset,
   skt_req_if.sink   req_bus,
   skt_rsp_if.source rsp_bus
   );

   cmd_type    cmd;
   result_type result;
   logic       result_valid;
   logic       result_ready;
   logic       start_ready;

   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff, rsp_data_in;

   assign cmd.kind = kind_type'(req_bus.kind);
   assign cmd.key  = req_bus.key;
   assign cmd.data = req_bus.record_data[DATA_BITS-1:0];
   assign req_bus.ready = start_ready;

   skt_engine u_engine (
      .clock        (clock),
      .reset        (reset),
      .start_valid  (req_bus.valid),
      .start_ready  (start_ready),
      .cmd          (cmd),
      .result_valid (result_valid),
      .result_ready (result_ready),
      .result       (result)
   );

   assign result_ready = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (result_valid && result_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = rsp_data_ff.status;
   assign rsp_bus.found_data  = rsp_data_ff.found_data;
   assign rsp_bus.entry_count = rsp_data_ff.entry_count;

endmodule

`default_nettype wire

>>> hdl/skt_checker.sv
// Port-level checks for the sorted key table, bound to the top level.
// Depends on skt_pkg and sorted_key_table.
`timescale 1ns / 1ps
`default_nettype none

module skt_checker
   import skt_pkg::*;
   (
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_valid,
   input wire logic                     req_ready,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_ready,
   input wire logic [STATUS_W-1:0]      rsp_status,
   input wire logic [REC_W-1:0]         rsp_found_data,
   input wire logic [COUNT_FIELD_W-1:0] rsp_entry_count
   );

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before it was taken");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_status) && $stable(rsp_found_data)
                                  && $stable(rsp_entry_count))
      else $error("stalled response changed");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken while one is in work");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_FULL |->
         rsp_entry_count == COUNT_FIELD_W'(CAPACITY))
      else $error("rejected insert with table not full");

   a_data_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_FOUND |-> rsp_found_data == '0)
      else $error("payload shown without a match");

endmodule

bind sorted_key_table skt_checker u_skt_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_status      (rsp_bus.status),
   .rsp_found_data  (rsp_bus.found_data),
   .rsp_entry_count (rsp_bus.entry_count)
);

`default_nettype wire

>>> bench/tb_sorted_key_table.sv
// Self-checking testbench for the sorted key table: directed and random requests
// against a predictor of the ordered table. Depends on skt_pkg, skt_if and sorted_key_table.
`timescale 1ns / 1ps

module tb_sorted_key_table;
   import skt_pkg::*;

   localparam int STALL_LIMIT   = 1000;
   localparam int RANDOM_ITEMS  = 1330;
   localparam int CALM_ITEMS    = 200;
   localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
   localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

   logic clock;
   logic reset;

   skt_req_if req_bus ();
   skt_rsp_if rsp_bus ();

   sorted_key_table dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   logic signed [KEY_W-1:0] model_keys [CAPACITY];
   logic [DATA_BITS-1:0]    model_data [CAPACITY];
   int                      model_fill;
   result_type              pending_results [$];
   int                      mismatch_count;
   int                      quiet_cycles;
   bit                      idle_on;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic result_type predict_table_step(kind_type kind,
                                                     logic signed [KEY_W-1:0] key,
                                                     logic [REC_W-1:0] data);
      result_type r;
      int         pos;
      bit         hit;
      r.status     = STATUS_NOT_FOUND;
      r.found_data = '0;
      hit          = 1'b0;
      if (kind == KIND_INSERT) begin
         if (model_fill >= CAPACITY) begin
            r.status = STATUS_FULL;
         end else begin
            pos = model_fill;
            for (int i = 0; i < model_fill; i++) begin
               if (pos == model_fill && key < model_keys[i]) pos = i;
            end
            for (int i = CAPACITY - 1; i > 0; i--) begin
               if (i > pos && i <= model_fill) begin
                  model_keys[i] = model_keys[i-1];
                  model_data[i] = model_data[i-1];
               end
            end
            model_keys[pos] = key;
            model_data[pos] = data[DATA_BITS-1:0];
            model_fill++;
            r.status = STATUS_INSERTED;
         end
      end else begin
         for (int i = 0; i < model_fill; i++) begin
            if (!hit && model_keys[i] == key) begin
               hit          = 1'b1;
               r.status     = STATUS_FOUND;
               r.found_data = REC_W'(model_data[i]);
            end
         end
      end
      r.entry_count = model_fill[COUNT_FIELD_W-1:0];
      return r;
   endfunction

   task automatic send_request(kind_type kind, logic signed [KEY_W-1:0] key,
                               logic [REC_W-1:0] data);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.kind        <= kind;
      req_bus.key         <= key;
      req_bus.record_data <= data;
      do @(posedge clock); while (!req_bus.ready);
      pending_results.push_back(predict_table_step(kind, key, data));
      @(negedge clock);
   endtask

   task automatic wait_until_drained();
      do @(negedge clock); while (pending_results.size() != 0);
   endtask

   function automatic logic [REC_W-1:0] pick_data();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic test_empty_find();
      send_request(KIND_FIND, 32'sd0, '1);
      send_request(KIND_FIND, KEY_MIN, '0);
      send_request(KIND_FIND, KEY_MAX, 64'h0123_4567_89ab_cdef);
   endtask

   task automatic test_ordered_insert();
      send_request(KIND_INSERT, KEY_MAX, '1);
      send_request(KIND_INSERT, KEY_MIN, '0);
      send_request(KIND_INSERT, 32'sd0, 64'h5555_5555_5555_5555);
      send_request(KIND_INSERT, -32'sd1, 64'haaaa_aaaa_aaaa_aaaa);
      send_request(KIND_INSERT, 32'sd1, 64'h8000_0000_0000_0001);
      send_request(KIND_INSERT, 32'sd5, 64'h0000_0000_0000_00a1);
      send_request(KIND_INSERT, 32'sd5, 64'h0000_0000_0000_00b2);
      send_request(KIND_INSERT, 32'sd5, 64'h0000_0000_0000_00c3);
      send_request(KIND_INSERT, KEY_MAX, 64'hfeed_0000_0000_beef);
      send_request(KIND_FIND, 32'sd5, '0);
      send_request(KIND_FIND, KEY_MAX, '0);
      send_request(KIND_FIND, KEY_MIN, '1);
      send_request(KIND_FIND, 32'sd0, '0);
      send_request(KIND_FIND, -32'sd1, '0);
      send_request(KIND_FIND, 32'sd1, '0);
      send_request(KIND_FIND, 32'sd2, '0);
      send_request(KIND_FIND, -32'sd2, '0);
   endtask

   task automatic test_random_traffic(int count);
      logic signed [KEY_W-1:0] key;
      kind_type                kind;
      for (int n = 0; n < count; n++) begin
         if (n == count / 2) begin
            req_bus.valid <= 1'b0;
            wait_until_drained();
         end
         if (n == count - CALM_ITEMS) idle_on = 1'b0;
         if ($urandom_range(0, 7) < ((model_fill < CAPACITY) ? 3 : 1)) begin
            kind = KIND_INSERT;
            if ($urandom_range(0, 1) == 0) begin
               key = $urandom_range(0, 10);
               key = key - 32'sd5;
            end else begin
               key = $urandom;
            end
         end else begin
            kind = KIND_FIND;
            case ($urandom_range(0, 5))
               0, 1, 2: key = (model_fill > 0) ? model_keys[$urandom_range(0, model_fill - 1)]
                                               : $urandom;
               3:       key = (model_fill > 0) ? model_keys[$urandom_range(0, model_fill - 1)] + 1
                                               : KEY_MIN;
               4:       key = $urandom_range(0, 1) ? KEY_MIN : KEY_MAX;
               default: key = $urandom;
            endcase
         end
         send_request(kind, key, pick_data());
      end
   endtask

   task automatic test_full_table();
      send_request(KIND_INSERT, KEY_MIN, '1);
      send_request(KIND_INSERT, KEY_MAX, '1);
      send_request(KIND_FIND, KEY_MIN, '0);
      send_request(KIND_FIND, KEY_MAX, '0);
   endtask

   initial begin
      req_bus.valid       <= 1'b0;
      req_bus.kind        <= KIND_INSERT;
      req_bus.key         <= '0;
      req_bus.record_data <= '0;
      model_fill     = 0;
      mismatch_count = 0;
      idle_on        = 1'b0;
      reset = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_empty_find();
      test_ordered_insert();
      idle_on = 1'b1;
      test_random_traffic(RANDOM_ITEMS);
      test_full_table();
      req_bus.valid <= 1'b0;
      wait_until_drained();
      repeat (CAPACITY + 8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      forever begin
         if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin : check_responses
      result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_results.size() == 0) begin
            $error("response: no request outstanding, status %0d", rsp_bus.status);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_bus.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_bus.status);
               mismatch_count++;
            end
            if (rsp_bus.found_data !== want.found_data) begin
               $error("found_data: expected %h, actual %h", want.found_data,
                      rsp_bus.found_data);
               mismatch_count++;
            end
            if (rsp_bus.entry_count !== want.entry_count) begin
               $error("entry_count: expected %0d, actual %0d", want.entry_count,
                      rsp_bus.entry_count);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule

>>> filelist.f
hdl/skt_pkg.sv
hdl/skt_if.sv
hdl/skt_engine.sv
hdl/sorted_key_table.sv
hdl/skt_checker.sv
bench/tb_sorted_key_table.sv
